>>> hdl/osset_pkg.sv
`default_nettype none
package osset_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_KTH    = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOCHG   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADRANK = 2'd3
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    load;
    logic                    ins;
    logic                    del;
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        rank_idx;
    logic [CNT_W-1:0]        occ;
  } osset_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    lt;
    logic                    gt;
  } osset_link_t;

endpackage
`default_nettype wire

>>> hdl/osset_if.sv
`default_nettype none
interface osset_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic signed [31:0]          operand;

  modport source (output valid, output operation, output operand, input ready);
  modport sink   (input valid, input operation, input operand, output ready);
endinterface

interface osset_rsp_if;
  logic                        valid;
  logic                        ready;
  logic signed [31:0]          value;
  logic [1:0]                  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/osset_cell.sv
`default_nettype none
module osset_cell (
  input  wire logic                      clk,
  input  wire osset_pkg::osset_ctl_t     ctl,
  input  wire logic [osset_pkg::IDX_W-1:0] idx,
  input  wire osset_pkg::osset_link_t    left,
  input  wire osset_pkg::osset_link_t    right,
  output osset_pkg::osset_link_t         link,
  output logic                           eq_r,
  output logic [osset_pkg::KEY_W-1:0]    contrib_r
);
  import osset_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic                    lt_r;
  logic                    gt_r;
  logic                    vld;
  logic                    lt;
  logic                    eq;
  logic [CNT_W-1:0]        pos1;
  logic [KEY_W-1:0]        contrib_nxt;

  always_comb begin
    vld  = CNT_W'(idx) < ctl.occ;
    lt   = vld && ($signed(key_r) < $signed(ctl.key));
    eq   = vld && (key_r == ctl.key);
    pos1 = CNT_W'(idx) + CNT_W'(1);
    case (ctl.op)
      OP_KTH: begin
        contrib_nxt = (idx == ctl.rank_idx) ? key_r : '0;
      end
      OP_COUNT: begin
        contrib_nxt = (lt && !right.lt) ? {{(KEY_W-CNT_W){1'b0}}, pos1} : '0;
      end
      default: begin
        contrib_nxt = '0;
      end
    endcase
  end

  assign link.key = key_r;
  assign link.lt  = lt;
  assign link.gt  = gt_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lt_r      <= lt;
      gt_r      <= !lt && !eq;
      eq_r      <= eq;
      contrib_r <= contrib_nxt;
    end else if (ctl.ins && gt_r) begin
      key_r <= left.gt ? left.key : ctl.key;
    end else if (ctl.del && !lt_r) begin
      key_r <= right.key;
    end
  end

endmodule
`default_nettype wire

>>> hdl/order_statistic_set.sv
// order_statistic_set: sorted set of distinct signed 32-bit keys
//
// in_req carries one request word (operation, operand); out_rsp returns one
// word (value, status) per request, in request order. valid/ready handshake
// on both sides, a word moves when both are high.
// the keys live in a row of compare cells, one key per cell, kept ascending.
// first, on acceptance, every cell compares its key with the operand and
// registers its flags and its share of the answer. then, once the output
// register is free, the shares are or-ed into the result, and an insert or
// delete shifts the row by one cell in place. a new request is accepted
// only in idle, after the last one has finished its merge/shift step.
// reset clears the occupancy; the set is empty and stored keys are ignored.
// the result sits in an output register; a new request is taken while it
// waits, but that request holds in its merge/shift step until the register
// frees up, so a stalled receiver stops the block after one more request.
`default_nettype none
module order_statistic_set (
  input  wire logic   clk,
  input  wire logic   rst_n,
  osset_req_if.sink   in_req,
  osset_rsp_if.source out_rsp
);
  import osset_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  op_t                     op_r;
  logic signed [KEY_W-1:0] opnd_r;
  logic                    bad_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_value_r, out_value_nxt;
  status_t                 out_status_r, out_status_nxt;

  osset_ctl_t              ctl;
  osset_link_t             links   [CAPACITY];
  logic                    eqs     [CAPACITY];
  logic [KEY_W-1:0]        contribs[CAPACITY];

  logic                    accept;
  logic                    commit;
  logic                    found;
  logic [KEY_W-1:0]        merged;
  logic                    do_ins;
  logic                    do_del;
  logic                    rank_bad;

  assign in_req.ready  = (state_r == S_IDLE);
  assign accept        = in_req.valid && in_req.ready;
  assign commit        = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.value  = out_value_r;
  assign out_rsp.status = out_status_r;

  assign rank_bad = in_req.operand[KEY_W-1] || (in_req.operand == '0) ||
                    ($unsigned(in_req.operand) > {{(KEY_W-CNT_W){1'b0}}, occ_r});

  always_comb begin
    ctl.load     = accept;
    ctl.ins      = do_ins;
    ctl.del      = do_del;
    ctl.op       = accept ? op_t'(in_req.operation) : op_r;
    ctl.key      = accept ? in_req.operand : opnd_r;
    ctl.rank_idx = in_req.operand[IDX_W-1:0] - IDX_W'(1);
    ctl.occ      = occ_r;
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    osset_link_t lnk_left;
    osset_link_t lnk_right;
    if (gi == 0) begin : g_first
      assign lnk_left = '0;
    end else begin : g_mid
      assign lnk_left = links[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign lnk_right = '0;
    end else begin : g_body
      assign lnk_right = links[gi+1];
    end
    osset_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(gi)),
      .left      (lnk_left),
      .right     (lnk_right),
      .link      (links[gi]),
      .eq_r      (eqs[gi]),
      .contrib_r (contribs[gi])
    );
  end

  always_comb begin
    found  = 1'b0;
    merged = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found  = found | eqs[i];
      merged = merged | contribs[i];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    do_ins         = 1'b0;
    do_del         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          case (op_r)
            OP_INSERT: begin
              if (found) begin
                out_status_nxt = ST_NOCHG;
              end else if (occ_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_DONE;
                do_ins         = 1'b1;
                occ_nxt        = occ_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (found) begin
                out_status_nxt = ST_DONE;
                do_del         = 1'b1;
                occ_nxt        = occ_r - CNT_W'(1);
              end else begin
                out_status_nxt = ST_NOCHG;
              end
            end
            OP_KTH: begin
              if (bad_r) begin
                out_status_nxt = ST_BADRANK;
              end else begin
                out_status_nxt = ST_DONE;
                out_value_nxt  = merged;
              end
            end
            default: begin
              out_status_nxt = ST_DONE;
              out_value_nxt  = merged;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      op_r   <= op_t'(in_req.operation);
      opnd_r <= in_req.operand;
      bad_r  <= rank_bad;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_word_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result word without a finished request");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> occ_r == $past(occ_r) + CNT_W'(1))
    else $error("insert did not grow the set");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == OP_COUNT) |-> merged <= {{(KEY_W-CNT_W){1'b0}}, occ_r})
    else $error("count above occupancy");

endmodule
`default_nettype wire

>>> test/order_statistic_set_checker.sv
`timescale 1ns / 100ps
module order_statistic_set_checker (
  input  logic clk,
  input  logic rst_n,
  osset_req_if req_mon,
  osset_rsp_if rsp_mon,
  output int   mismatches,
  output int   outstanding
);
  import osset_pkg::*;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    status_t                 status;
  } answer_t;

  logic signed [KEY_W-1:0] held_keys [CAPACITY];
  int                      held_count;
  int                      error_total;
  answer_t                 awaited_answers[$];

  // number of held keys strictly below the given key
  function automatic int keys_below(input logic signed [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (held_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic answer_t apply_request(input op_t op, input logic signed [KEY_W-1:0] arg);
    answer_t ans;
    int      pos;
    int      i;
    ans.value  = '0;
    ans.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        pos = keys_below(arg);
        if (pos < held_count && held_keys[pos] == arg) begin
          ans.status = ST_NOCHG;
        end else if (held_count >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = arg;
          held_count++;
        end
      end
      OP_DELETE: begin
        pos = keys_below(arg);
        if (pos < held_count && held_keys[pos] == arg) begin
          for (i = pos; i < held_count - 1; i++) held_keys[i] = held_keys[i+1];
          held_count--;
        end else begin
          ans.status = ST_NOCHG;
        end
      end
      OP_KTH: begin
        if (arg < 1 || arg > held_count) ans.status = ST_BADRANK;
        else ans.value = held_keys[arg-1];
      end
      OP_COUNT: begin
        ans.value = keys_below(arg);
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t due;
    if (!rst_n) begin
      held_count = 0;
      error_total = 0;
      awaited_answers.delete();
    end else begin
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (awaited_answers.size() == 0) begin
          $error("unexpected result word: value %0d, status %0d",
                 rsp_mon.value, rsp_mon.status);
          error_total++;
        end else begin
          due = awaited_answers.pop_front();
          if (rsp_mon.value !== due.value) begin
            $error("value: expected %0d, got %0d", due.value, rsp_mon.value);
            error_total++;
          end
          if (rsp_mon.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_mon.status);
            error_total++;
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
        awaited_answers.push_back(apply_request(op_t'(req_mon.operation), req_mon.operand));
    end
    mismatches  <= error_total;
    outstanding <= awaited_answers.size();
  end

endmodule

>>> test/order_statistic_set_tb.sv
`timescale 1ns / 100ps
module order_statistic_set_tb;
  import osset_pkg::*;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam int FILL_WORDS = 1100;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet;
  int   mismatches;
  int   outstanding;
  int   words_sent;
  int   rsp_hold;
  logic rsp_taken;

  osset_req_if in_req();
  osset_rsp_if out_rsp();

  order_statistic_set DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  order_statistic_set_checker set_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_req),
    .rsp_mon     (out_rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // receiver may stall after a result word, at random; no new stall starts while quiet
  always @(posedge clk) rsp_taken <= rst_n && out_rsp.valid && out_rsp.ready;

  always @(negedge clk) begin
    if (rsp_taken === 1'b1 && !quiet) rsp_hold = $urandom_range(0, 3);
    out_rsp.ready <= (rsp_hold == 0);
    if (rsp_hold > 0) rsp_hold--;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_word(input op_t op, input logic signed [KEY_W-1:0] arg);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_req.valid <= 1'b0;
    end
    @(negedge clk);
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.operand   <= arg;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    words_sent++;
    if (words_sent % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] mixed_key();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return KEY_MIN;
    if (pick == 1) return KEY_MAX;
    if (pick < 4) return $urandom;
    return int'($urandom_range(0, 127)) - 64;
  endfunction

  function automatic logic signed [KEY_W-1:0] probe_rank(input int span);
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return $urandom;
    if (pick == 1) return -int'($urandom_range(1, 4));
    return int'($urandom_range(0, span));
  endfunction

  // odd multiplier keeps fill keys distinct
  function automatic logic signed [KEY_W-1:0] fill_key(input int idx);
    return idx * 32'sh9E3779B1 + 32'sh13579BDF;
  endfunction

  initial begin : stimulus
    int i;
    int pick;
    rst_n            = 1'b0;
    in_req.valid     = 1'b0;
    in_req.operation = OP_INSERT;
    in_req.operand   = '0;
    quiet            = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, extremes, ranks at and past the edges
    send_word(OP_COUNT, 0);
    send_word(OP_KTH, 1);
    send_word(OP_DELETE, 5);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, -1);
    send_word(OP_INSERT, 1);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_KTH, 0);
    send_word(OP_KTH, 1);
    send_word(OP_KTH, 5);
    send_word(OP_KTH, 6);
    send_word(OP_KTH, -1);
    send_word(OP_KTH, KEY_MIN);
    send_word(OP_KTH, KEY_MAX);
    send_word(OP_COUNT, KEY_MIN);
    send_word(OP_COUNT, KEY_MAX);
    send_word(OP_COUNT, 0);
    send_word(OP_DELETE, 0);
    send_word(OP_DELETE, 0);
    send_word(OP_DELETE, KEY_MIN);
    send_word(OP_DELETE, KEY_MAX);
    drain_results();

    // small key pool so inserts, deletes and duplicates collide often
    for (i = 0; i < 350; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) send_word(OP_INSERT, mixed_key());
      else if (pick < 13) send_word(OP_DELETE, mixed_key());
      else if (pick < 16) send_word(OP_KTH, probe_rank(80));
      else send_word(OP_COUNT, mixed_key());
    end
    drain_results();

    // fill to capacity and beyond
    for (i = 0; i < FILL_WORDS; i++) begin
      send_word(OP_INSERT, fill_key(i));
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) send_word(OP_KTH, probe_rank(i + 40));
        else send_word(OP_COUNT, $urandom);
      end
    end
    drain_results();

    // hover around full
    for (i = 0; i < 300; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) send_word(OP_INSERT, fill_key(2000 + i));
      else if (pick == 2) send_word(OP_INSERT, fill_key($urandom_range(0, FILL_WORDS - 1)));
      else if (pick < 5) send_word(OP_DELETE, fill_key($urandom_range(0, FILL_WORDS - 1)));
      else if (pick < 7) send_word(OP_KTH, int'($urandom_range(1000, 1030)));
      else send_word(OP_COUNT, $urandom);
    end
    drain_results();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
